### hw/rtl/gls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gls_pkg: shared constants, register map and lookup tables
// Holds the sizing constants, the register indexes, the controller state
// codes and the two profile tables (half cosine, gaussian brightness) that
// are built at elaboration.
// ----------------------------------------------------------------------------
package gls_pkg;

  localparam int unsigned MAX_LEDS       = 64;
  localparam int unsigned COS_TABLE_SIZE = 256;  // power of two, 64..4096

  localparam int unsigned COS_BITS = $clog2(COS_TABLE_SIZE);
  localparam int unsigned PH_W     = COS_BITS + 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PER_W    = 16;
  localparam int unsigned DVD_W    = (PER_W + PH_W > TIME_W) ? PER_W + PH_W : TIME_W;
  localparam int unsigned CNT_W    = $clog2(DVD_W);
  localparam int unsigned LED_IW   = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int unsigned HC_W     = 17;  // Q16, 0..65536
  localparam int unsigned RED_DEPTH = 240;
  localparam int unsigned ADDR_W   = 4;

  // register indexes (word address bits)
  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_START  = 2'd1;
  localparam logic [1:0] REG_COUNT  = 2'd2;

  localparam logic [15:0] PERIOD_RST = 16'd2000;
  localparam logic [7:0]  START_RST  = 8'd0;
  localparam logic [6:0]  COUNT_RST  = 7'd16;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_DIV_MOD = 7'b0000010,
    ST_DIV_PH  = 7'b0000100,
    ST_POS_A   = 7'b0001000,
    ST_POS_B   = 7'b0010000,
    ST_CENTER  = 7'b0100000,
    ST_EMIT    = 7'b1000000
  } state_e;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  typedef logic [HC_W-1:0] hcos_lut_t [COS_TABLE_SIZE];
  typedef logic [7:0]      red_lut_t  [RED_DEPTH];

  // (1 + cos(2*pi*k/size)) / 2 in Q16, Taylor series folded into the first quadrant
  function automatic logic [HC_W-1:0] half_cos(input logic [63:0] k);
    logic [63:0] a, m, y, y2, t, s, r;
    logic        neg;
    a   = (k <= 64'(COS_TABLE_SIZE) - k) ? k : 64'(COS_TABLE_SIZE) - k;
    m   = 2 * a;
    neg = 1'b0;
    if (2 * m > 64'(COS_TABLE_SIZE)) begin
      neg = 1'b1;
      m   = 64'(COS_TABLE_SIZE) - m;
    end
    y  = (PI_Q30 * m) / COS_TABLE_SIZE;
    y2 = (y * y) >> 30;
    t  = Q30_ONE;
    s  = ((y2 * t) >> 30) / 64'd132;
    t  = (s >= Q30_ONE) ? 64'd0 : Q30_ONE - s;
    s  = ((y2 * t) >> 30) / 64'd90;
    t  = (s >= Q30_ONE) ? 64'd0 : Q30_ONE - s;
    s  = ((y2 * t) >> 30) / 64'd56;
    t  = (s >= Q30_ONE) ? 64'd0 : Q30_ONE - s;
    s  = ((y2 * t) >> 30) / 64'd30;
    t  = (s >= Q30_ONE) ? 64'd0 : Q30_ONE - s;
    s  = ((y2 * t) >> 30) / 64'd12;
    t  = (s >= Q30_ONE) ? 64'd0 : Q30_ONE - s;
    s  = ((y2 * t) >> 30) / 64'd2;
    t  = (s >= Q30_ONE) ? 64'd0 : Q30_ONE - s;
    if (neg) r = (Q30_ONE - t + (64'd1 << 14)) >> 15;
    else     r = (Q30_ONE + t + (64'd1 << 14)) >> 15;
    return r[HC_W-1:0];
  endfunction

  // floor(num / den) by shift and subtract, one quotient bit per step
  function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // 255 * exp(-dist^2/32) for a Q4 distance, via exp(x/8) and three squarings
  function automatic logic [7:0] gauss_red(input logic [63:0] dq);
    logic [63:0] x, e, v, red;
    x = (dq * dq) << 14;
    e = Q30_ONE;
    e = Q30_ONE + ((x * e) >> 30) / 64'd12;
    e = Q30_ONE + ((x * e) >> 30) / 64'd11;
    e = Q30_ONE + ((x * e) >> 30) / 64'd10;
    e = Q30_ONE + ((x * e) >> 30) / 64'd9;
    e = Q30_ONE + ((x * e) >> 30) / 64'd8;
    e = Q30_ONE + ((x * e) >> 30) / 64'd7;
    e = Q30_ONE + ((x * e) >> 30) / 64'd6;
    e = Q30_ONE + ((x * e) >> 30) / 64'd5;
    e = Q30_ONE + ((x * e) >> 30) / 64'd4;
    e = Q30_ONE + ((x * e) >> 30) / 64'd3;
    e = Q30_ONE + ((x * e) >> 30) / 64'd2;
    e = Q30_ONE + ((x * e) >> 30);
    v = long_div((64'd1 << 60) + (e >> 1), e);
    v = (v * v + (64'd1 << 29)) >> 30;
    v = (v * v + (64'd1 << 29)) >> 30;
    v = (v * v + (64'd1 << 29)) >> 30;
    red = (64'd255 * v + (64'd1 << 29)) >> 30;
    return (red > 64'd255) ? 8'd255 : red[7:0];
  endfunction

  function automatic hcos_lut_t build_hcos();
    hcos_lut_t lut;
    for (int k = 0; k < COS_TABLE_SIZE; k++) lut[k] = half_cos(64'(k));
    return lut;
  endfunction

  function automatic red_lut_t build_red();
    red_lut_t lut;
    for (int k = 0; k < RED_DEPTH; k++) lut[k] = gauss_red(64'(k));
    return lut;
  endfunction

  localparam hcos_lut_t HCOS_LUT = build_hcos();
  localparam red_lut_t  RED_LUT  = build_red();

endpackage

### hw/rtl/gaussian_led_scanner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_led_scanner_core: back-and-forth LED sweep with gaussian falloff
// One frame tick in, one red level per LED out, last pixel flagged.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one time_ms beat per frame.
//   Output channel (out_valid_o / out_stall_i) returns led_count pixel beats
//   (clamped to 64), in strip order, with last_pixel_o on the final one.
//   A led_count of zero gives no beats.
//   Per frame a shared restoring divider computes time mod period, then the
//   table phase; a shared 17x9 multiplier then forms the interpolated
//   position (ST_POS_A, ST_POS_B) and the scan center (ST_CENTER). Pixels
//   then leave one per cycle while the output is not stalled. in_stall_o
//   stays high after the input beat is taken until the last pixel is loaded
//   (a zero period skips the divider), so a new frame is taken only once
//   the previous one is through. A stalled output beat holds in the output
//   register and pixel generation waits for it. Reset restores period
//   2000 ms, start 0, count 16 and drops any frame in work. Configuration
//   goes over the APB port (0x0 period_ms, 0x4 start_led, 0x8 led_count);
//   the user must write it only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module gaussian_led_scanner_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gls_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // frame ticks
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [31:0]                 time_ms_i,
  // pixels
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [8:0]                  pixel_index_o,
  output logic [7:0]                  red_level_o,
  output logic                        last_pixel_o
);
  import gls_pkg::*;

  // configuration registers
  logic [15:0] period_q;
  logic [7:0]  start_q;
  logic [6:0]  count_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
      start_q  <= START_RST;
      count_q  <= COUNT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_PERIOD: period_q <= pwdata[15:0];
        REG_START:  start_q  <= pwdata[7:0];
        REG_COUNT:  count_q  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PERIOD: prdata = {16'd0, period_q};
      REG_START:  prdata = {24'd0, start_q};
      REG_COUNT:  prdata = {25'd0, count_q};
      default:    prdata = 32'd0;
    endcase
  end

  // datapath registers
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [15:0]       rem_q, rem_d;
  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [24:0]       acc_q, acc_d;
  logic [16:0]       pos_q, pos_d;
  logic [23:0]       center_q, center_d;
  logic [6:0]        n_q, n_d;
  logic [LED_IW-1:0] i_q, i_d;
  logic              out_valid_q, out_valid_d;
  logic [8:0]        pix_q, pix_d;
  logic [7:0]        red_q, red_d;
  logic              last_q, last_d;

  // shared divider step
  logic [16:0]       rem_sh;
  logic              div_ge;
  logic [15:0]       rem_nx;
  logic [DVD_W-1:0]  dvd_nx;
  logic              div_done;

  assign rem_sh   = {rem_q, dvd_q[DVD_W-1]};
  assign div_ge   = rem_sh >= {1'b0, period_q};
  assign rem_nx   = div_ge ? 16'(rem_sh - {1'b0, period_q}) : rem_sh[15:0];
  assign dvd_nx   = {dvd_q[DVD_W-2:0], div_ge};
  assign div_done = cnt_q == CNT_W'(DVD_W - 1);

  // phase split: table index and interpolation fraction
  logic [PH_W-1:0]     ph;
  logic [COS_BITS-1:0] k_idx, k1_idx;
  logic [7:0]          frac;

  assign ph     = dvd_q[PH_W-1:0];
  assign k_idx  = ph[PH_W-1:8];
  assign k1_idx = k_idx + COS_BITS'(1);
  assign frac   = ph[7:0];

  // shared multiplier
  logic [16:0] mul_a;
  logic [8:0]  mul_b;
  logic [25:0] prod;
  logic [25:0] pos_sum;

  always_comb begin
    unique case (state_q)
      ST_POS_A: begin
        mul_a = HCOS_LUT[k_idx];
        mul_b = 9'd256 - {1'b0, frac};
      end
      ST_POS_B: begin
        mul_a = HCOS_LUT[k1_idx];
        mul_b = {1'b0, frac};
      end
      default: begin
        mul_a = pos_q;
        mul_b = {2'b00, n_q};
      end
    endcase
  end

  assign prod    = 26'(mul_a * mul_b);
  assign pos_sum = {1'b0, acc_q} + {1'b0, prod[24:0]} + 26'd128;

  // pixel distance and brightness
  logic [23:0] iq, px_dist;
  logic [24:0] dist_rnd;
  logic [12:0] dq;
  logic [7:0]  red_px;
  logic        px_last;
  logic        px_load;
  logic [6:0]  n_eff;
  logic        in_acc;

  assign iq       = 24'({i_q, 16'd0});
  assign px_dist  = (iq >= center_q) ? iq - center_q : center_q - iq;
  assign dist_rnd = {1'b0, px_dist} + 25'd2048;
  assign dq       = dist_rnd[24:12];
  assign red_px   = (dq >= 13'(RED_DEPTH)) ? 8'd0 : RED_LUT[dq[7:0]];
  assign px_last  = 7'(i_q) == n_q - 7'd1;
  assign px_load  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign n_eff    = (count_q > 7'(MAX_LEDS)) ? 7'(MAX_LEDS) : count_q;
  assign in_acc   = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    acc_d       = acc_q;
    pos_d       = pos_q;
    center_d    = center_q;
    n_d         = n_q;
    i_d         = i_q;
    pix_d       = pix_q;
    red_d       = red_q;
    last_d      = last_q;
    out_valid_d = out_valid_q & out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && n_eff != 7'd0) begin
          n_d   = n_eff;
          cnt_d = '0;
          rem_d = '0;
          if (period_q == 16'd0) begin
            // zero period: phase is zero, go straight to the position
            dvd_d   = '0;
            state_d = ST_POS_A;
          end else begin
            dvd_d   = DVD_W'(time_ms_i);
            state_d = ST_DIV_MOD;
          end
        end
      end
      ST_DIV_MOD: begin
        cnt_d = cnt_q + CNT_W'(1);
        rem_d = rem_nx;
        dvd_d = dvd_nx;
        if (div_done) begin
          // restart the divider on remainder << phase bits
          cnt_d   = '0;
          rem_d   = '0;
          dvd_d   = DVD_W'({rem_nx, {PH_W{1'b0}}});
          state_d = ST_DIV_PH;
        end
      end
      ST_DIV_PH: begin
        cnt_d = cnt_q + CNT_W'(1);
        rem_d = rem_nx;
        dvd_d = dvd_nx;
        if (div_done) state_d = ST_POS_A;
      end
      ST_POS_A: begin
        acc_d   = prod[24:0];
        state_d = ST_POS_B;
      end
      ST_POS_B: begin
        pos_d   = pos_sum[24:8];
        state_d = ST_CENTER;
      end
      ST_CENTER: begin
        center_d = prod[23:0];
        i_d      = '0;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (px_load) begin
          out_valid_d = 1'b1;
          pix_d       = {1'b0, start_q} + 9'(i_q);
          red_d       = red_px;
          last_d      = px_last;
          if (px_last) state_d = ST_IDLE;
          else         i_d = i_q + LED_IW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      i_q         <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      i_q         <= i_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    dvd_q    <= dvd_d;
    acc_q    <= acc_d;
    pos_q    <= pos_d;
    center_q <= center_d;
    pix_q    <= pix_d;
    red_q    <= red_d;
    last_q   <= last_d;
  end

  assign in_stall_o    = state_q != ST_IDLE;
  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = pix_q;
  assign red_level_o   = red_q;
  assign last_pixel_o  = last_q;

  // checks
  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> 7'(i_q) < n_q)
    else $error("pixel counter ran past led count");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && n_eff != 7'd0 |=> in_stall_o)
    else $error("frame accepted but block not busy");

  a_rem_below_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV_MOD || state_q == ST_DIV_PH |-> rem_q < period_q)
    else $error("divider remainder not below period");

  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CENTER |-> pos_q <= 17'h10000)
    else $error("scan position above one");

endmodule
